// ----- src/qte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion to Euler conversion
// Word formats, working widths, the CORDIC arctangent table and the
// pre-rotation and rounding functions used by several modules.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int COMP_W   = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 34;
    localparam int LANE_W   = 38;
    localparam int ACC_W    = 34;
    localparam int ANG_W    = 16;
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = 32;
    localparam int TAB_LEN  = 24;

    localparam logic signed [SUM_W-1:0] ONE_WORK   = SUM_W'(64'sd1073741824);
    localparam logic [SQ_W-1:0]         ONE_SQUARE = SQ_W'(1) << 60;
    localparam logic signed [ACC_W-1:0] HALF_PI    = ACC_W'(64'sd1073741824);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd32768);

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        t_comp comp_x;
        t_comp comp_y;
        t_comp comp_z;
        t_comp comp_w;
    } t_quat;

    typedef struct packed {
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] yaw_angle;
        logic signed [ANG_W-1:0] roll_angle;
        logic                    pitch_clamped;
    } t_euler;

    typedef struct packed {
        logic signed [31:0]      sp;
        logic signed [SUM_W-1:0] ys;
        logic signed [SUM_W-1:0] yc;
        logic signed [SUM_W-1:0] rs;
        logic signed [SUM_W-1:0] rc;
        logic                    clamped;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        t_side           side;
    } t_sqrt_item;

    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic                     zero;
    } t_lane;

    typedef struct packed {
        t_lane pitch;
        t_lane yaw;
        t_lane roll;
        logic  clamped;
    } t_cord_item;

    function automatic t_lane prerotate(input logic signed [SUM_W-1:0] y,
                                        input logic signed [SUM_W-1:0] x);
        t_lane l;
        logic signed [LANE_W-1:0] xe;
        logic signed [LANE_W-1:0] ye;
        xe = LANE_W'(x);
        ye = LANE_W'(y);
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                l.y   = -xe;
                l.x   = ye;
                l.acc = HALF_PI;
            end else begin
                l.y   = xe;
                l.x   = -ye;
                l.acc = -HALF_PI;
            end
        end else begin
            l.y   = ye;
            l.x   = xe;
            l.acc = '0;
        end
        return l;
    endfunction

    function automatic logic signed [ANG_W-1:0] round_angle(input t_lane l);
        logic signed [ACC_W-1:0] s;
        s = l.acc + ROUND_HALF;
        return l.zero ? '0 : s[31:16];
    endfunction

endpackage
`default_nettype wire

// ----- src/qte_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_front: products, sums and root operand
// Three register stages: the nine component products, the sine and cosine
// operands with the pitch clamp, and the radicand one minus sine squared.
// ----------------------------------------------------------------------------
module qte_front (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire qte_pkg::t_quat     i_quat,
    output qte_pkg::t_sqrt_item     o_item
);
    import qte_pkg::*;

    logic signed [PROD_W-1:0] r_wy, r_zx, r_wz, r_xy, r_wx, r_yz, r_xx, r_yy, r_zz;
    t_side      r_side;
    t_sqrt_item r_item;

    logic signed [SUM_W-1:0] n_sp_raw;
    t_side                   n_side;
    logic [SQ_W-1:0]         n_square;

    always_comb begin
        n_sp_raw       = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        n_side.ys      = (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        n_side.yc      = ONE_WORK - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        n_side.rs      = (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        n_side.rc      = ONE_WORK - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        n_side.clamped = 1'b0;
        n_side.sp      = 32'(n_sp_raw);
        if (n_sp_raw > ONE_WORK) begin
            n_side.sp      = 32'(ONE_WORK);
            n_side.clamped = 1'b1;
        end
        if (n_sp_raw < -ONE_WORK) begin
            n_side.sp      = 32'(-ONE_WORK);
            n_side.clamped = 1'b1;
        end
        n_square = SQ_W'(SQ_W'(r_side.sp) * SQ_W'(r_side.sp));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wy <= PROD_W'(i_quat.comp_w) * PROD_W'(i_quat.comp_y);
            r_zx <= PROD_W'(i_quat.comp_z) * PROD_W'(i_quat.comp_x);
            r_wz <= PROD_W'(i_quat.comp_w) * PROD_W'(i_quat.comp_z);
            r_xy <= PROD_W'(i_quat.comp_x) * PROD_W'(i_quat.comp_y);
            r_wx <= PROD_W'(i_quat.comp_w) * PROD_W'(i_quat.comp_x);
            r_yz <= PROD_W'(i_quat.comp_y) * PROD_W'(i_quat.comp_z);
            r_xx <= PROD_W'(i_quat.comp_x) * PROD_W'(i_quat.comp_x);
            r_yy <= PROD_W'(i_quat.comp_y) * PROD_W'(i_quat.comp_y);
            r_zz <= PROD_W'(i_quat.comp_z) * PROD_W'(i_quat.comp_z);
            r_side <= n_side;
            r_item.rem  <= ONE_SQUARE - n_square;
            r_item.root <= '0;
            r_item.side <= r_side;
        end
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

// ----- src/qte_sqrt_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_sqrt_step: one stage of the bit-by-bit square root
// Tries one result bit against the remainder and registers the new
// remainder and partial root together with the side operands.
// ----------------------------------------------------------------------------
module qte_sqrt_step #(
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire qte_pkg::t_sqrt_item i_item,
    output qte_pkg::t_sqrt_item      o_item
);
    import qte_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * STEP);

    logic [SQ_W-1:0] trial;
    t_sqrt_item      n_item;
    t_sqrt_item      r_item;

    always_comb begin
        trial       = i_item.root + BIT;
        n_item.side = i_item.side;
        if (i_item.rem >= trial) begin
            n_item.rem  = i_item.rem - trial;
            n_item.root = (i_item.root >> 1) + BIT;
        end else begin
            n_item.rem  = i_item.rem;
            n_item.root = i_item.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

// ----- src/qte_cordic_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic_step: one vectoring CORDIC iteration on three lanes
// Pitch, yaw and roll each rotate toward the x axis by the angle of this
// step and accumulate it.
// ----------------------------------------------------------------------------
module qte_cordic_step #(
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire qte_pkg::t_cord_item i_item,
    output qte_pkg::t_cord_item      o_item
);
    import qte_pkg::*;

    localparam logic signed [ACC_W-1:0] ANGLE = ACC_W'(ATAN_TAB[STEP]);

    function automatic t_lane rotate(input t_lane l);
        t_lane r;
        logic signed [LANE_W-1:0] dx;
        logic signed [LANE_W-1:0] dy;
        dx     = $signed(l.y) >>> STEP;
        dy     = $signed(l.x) >>> STEP;
        r.zero = l.zero;
        if ($signed(l.y) > 0) begin
            r.x   = l.x + dx;
            r.y   = l.y - dy;
            r.acc = l.acc + ANGLE;
        end else begin
            r.x   = l.x - dx;
            r.y   = l.y + dy;
            r.acc = l.acc - ANGLE;
        end
        return r;
    endfunction

    t_cord_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.pitch   <= rotate(i_item.pitch);
            r_item.yaw     <= rotate(i_item.yaw);
            r_item.roll    <= rotate(i_item.roll);
            r_item.clamped <= i_item.clamped;
        end
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

// ----- src/quaternion_to_euler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler: quaternion to pitch, yaw and roll binary angles
// Fully pipelined conversion with an output register and a skid stage.
// ----------------------------------------------------------------------------
// The block accepts one quaternion word per clock and returns one angle word
// per clock while the output is ready and the skid stage is empty. A word
// passes three front stages for products and sums, 32 square root stages,
// one quadrant stage, one stage per CORDIC iteration and the output register.
// Output back-pressure first fills a one-word skid stage, so input ready
// drops only after two words wait at the output.
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire qte_pkg::t_quat   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output qte_pkg::t_euler       o_out_data
);
    import qte_pkg::*;

    localparam int STAGES = 3 + SQ_STEPS + 1 + CORDIC_STEPS;

    logic              w_en;
    logic [STAGES-1:0] r_vld;
    t_sqrt_item        s_chain [SQ_STEPS+1];
    t_cord_item        c_chain [CORDIC_STEPS+1];
    t_cord_item        r_pre;
    t_euler            w_word;
    t_euler            r_out;
    t_euler            r_skid;
    logic              r_out_vld;
    logic              r_skid_vld;
    logic signed [SUM_W-1:0] w_cp;

    assign w_en = !r_skid_vld;

    qte_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quat (i_in_data),
        .o_item (s_chain[0])
    );

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        qte_sqrt_step #(.STEP(i)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_item (s_chain[i]),
            .o_item (s_chain[i+1])
        );
    end

    assign w_cp = $signed({1'b0, s_chain[SQ_STEPS].root[SUM_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre.pitch   <= prerotate(SUM_W'(s_chain[SQ_STEPS].side.sp), w_cp);
            r_pre.yaw     <= prerotate(s_chain[SQ_STEPS].side.ys, s_chain[SQ_STEPS].side.yc);
            r_pre.roll    <= prerotate(s_chain[SQ_STEPS].side.rs, s_chain[SQ_STEPS].side.rc);
            r_pre.clamped <= s_chain[SQ_STEPS].side.clamped;
        end
    end

    assign c_chain[0] = r_pre;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        qte_cordic_step #(.STEP(i)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_item (c_chain[i]),
            .o_item (c_chain[i+1])
        );
    end

    always_comb begin
        w_word.pitch_angle   = round_angle(c_chain[CORDIC_STEPS].pitch);
        w_word.yaw_angle     = round_angle(c_chain[CORDIC_STEPS].yaw);
        w_word.roll_angle    = round_angle(c_chain[CORDIC_STEPS].roll);
        w_word.pitch_clamped = c_chain[CORDIC_STEPS].clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_in_valid};
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= r_vld[STAGES-1];
            end else if (r_vld[STAGES-1]) begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_vld || i_out_ready) begin
                r_out <= w_word;
            end else begin
                r_skid <= w_word;
            end
        end else if (i_out_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid filled while output was free");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_out_ready |=> r_skid_vld && $stable(r_skid))
        else $error("skid word lost during stall");

endmodule
`default_nettype wire

// ----- tb/qte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_checker: result predictor and comparator for quaternion_to_euler
// Watches both channels, computes the expected angle word for every accepted
// quaternion word in fixed point, and compares each returned word in order.
// ----------------------------------------------------------------------------
module qte_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  qte_pkg::t_quat    i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  qte_pkg::t_euler   i_out_data,
    output int                o_errors,
    output int                o_pending
);
    import qte_pkg::*;

    localparam int STEPS = 16;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    t_euler euler_queue[$];
    int     errors;

    assign o_errors  = errors;
    assign o_pending = euler_queue.size();

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        return a * b;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned bitv;
        root = 0;
        rem  = v;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic logic [15:0] angle_of(longint y, longint x);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; acc = 64'sd1073741824;
            end else begin
                t = -y; y = x; x = t; acc = -64'sd1073741824;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x = x + dx; y = y - dy; acc = acc + longint'(ATAN_TAB[i]);
            end else begin
                x = x - dx; y = y + dy; acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        t = shr_floor(acc + 32768, 16);
        return t[15:0];
    endfunction

    function automatic t_euler euler_of(t_quat q);
        t_euler e;
        longint qx, qy, qz, qw, sp, cp;
        qx = q.comp_x; qy = q.comp_y; qz = q.comp_z; qw = q.comp_w;
        e.pitch_clamped = 1'b0;
        sp = 2 * (prod_q30(qw, qy) - prod_q30(qz, qx));
        if (sp > ONE_Q30) begin
            sp = ONE_Q30; e.pitch_clamped = 1'b1;
        end
        if (sp < -ONE_Q30) begin
            sp = -ONE_Q30; e.pitch_clamped = 1'b1;
        end
        cp = root_floor((64'd1 << 60) - longint'(sp * sp));
        e.pitch_angle = angle_of(sp, cp);
        e.yaw_angle   = angle_of(2 * (prod_q30(qw, qz) + prod_q30(qx, qy)),
                                 ONE_Q30 - 2 * (prod_q30(qy, qy) + prod_q30(qz, qz)));
        e.roll_angle  = angle_of(2 * (prod_q30(qw, qx) + prod_q30(qy, qz)),
                                 ONE_Q30 - 2 * (prod_q30(qx, qx) + prod_q30(qy, qy)));
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_euler exp_word;
        int     bad;
        bad = 0;
        if (!i_rst_n) begin
            errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                euler_queue.push_back(euler_of(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (euler_queue.size() == 0) begin
                    $error("unexpected word %h", i_out_data);
                    bad = bad + 1;
                end else begin
                    exp_word = euler_queue.pop_front();
                    if (exp_word.pitch_angle !== i_out_data.pitch_angle) begin
                        $error("pitch_angle expected %0d actual %0d",
                               exp_word.pitch_angle, i_out_data.pitch_angle);
                        bad = bad + 1;
                    end
                    if (exp_word.yaw_angle !== i_out_data.yaw_angle) begin
                        $error("yaw_angle expected %0d actual %0d",
                               exp_word.yaw_angle, i_out_data.yaw_angle);
                        bad = bad + 1;
                    end
                    if (exp_word.roll_angle !== i_out_data.roll_angle) begin
                        $error("roll_angle expected %0d actual %0d",
                               exp_word.roll_angle, i_out_data.roll_angle);
                        bad = bad + 1;
                    end
                    if (exp_word.pitch_clamped !== i_out_data.pitch_clamped) begin
                        $error("pitch_clamped expected %0d actual %0d",
                               exp_word.pitch_clamped, i_out_data.pitch_clamped);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0) begin
                errors <= errors + bad;
            end
        end
    end
endmodule

// ----- tb/tb_quaternion_to_euler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler: testbench top for quaternion_to_euler
// Drives directed and random quaternion words with random idling on both
// channels, a long output hold-off and a full drain, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;
    import qte_pkg::*;

    localparam int RANDOM_WORDS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 80;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    t_quat  in_data = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    t_euler out_data;
    int     errors;
    int     pending;
    int     cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_off = 1'b0;

    always #2 i_clk = ~i_clk;

    quaternion_to_euler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    qte_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_quaternion_to_euler: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, or a long hold-off when asked.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input t_quat q);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic t_comp pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return t_comp'($urandom_range(0, 15)) - 16'sd8;
            default: return t_comp'($urandom());
        endcase
    endfunction

    // Components bounded to half of full scale keep the pitch sine in range.
    function automatic t_quat unit_quat();
        t_quat q;
        q.comp_x = t_comp'($signed($urandom_range(0, 32767)) - 16384);
        q.comp_y = t_comp'($signed($urandom_range(0, 32767)) - 16384);
        q.comp_z = t_comp'($signed($urandom_range(0, 32767)) - 16384);
        q.comp_w = t_comp'($signed($urandom_range(0, 32767)) - 16384);
        return q;
    endfunction

    initial begin
        t_quat q;
        t_comp edges[6];
        edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000, 16'sh5a82};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff});
        send_word('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
        send_word('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_word('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_word('{16'sh0000, 16'sh7fff, 16'sh0000, 16'sh7fff});
        send_word('{16'sh0000, 16'sh8000, 16'sh0000, 16'sh7fff});
        send_word('{16'sh5a82, 16'sh0000, 16'sh0000, 16'sh5a82});
        send_word('{16'sh0000, 16'sh5a82, 16'sh0000, 16'sh5a82});
        send_word('{16'sh0000, 16'sh0000, 16'sh5a82, 16'sh5a82});
        send_word('{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000});
        send_word('{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000});
        send_word('{16'sh4000, 16'sh8000, 16'sh7fff, 16'sh0000});
        for (int i = 0; i < 8; i++) begin
            q.comp_x = edges[$urandom_range(0, 5)];
            q.comp_y = edges[$urandom_range(0, 5)];
            q.comp_z = edges[$urandom_range(0, 5)];
            q.comp_w = edges[$urandom_range(0, 5)];
            send_word(q);
        end

        // Sender pauses until every expected word has returned.
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        hold_off = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - 300) quiet = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                q.comp_x = pick_comp();
                q.comp_y = pick_comp();
                q.comp_z = pick_comp();
                q.comp_w = pick_comp();
            end else begin
                q = unit_quat();
            end
            send_word(q);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_quaternion_to_euler: clean");
        end else begin
            $display("tb_quaternion_to_euler: errors");
        end
        $finish;
    end
endmodule

// ----- quaternion_to_euler.f -----
src/qte_pkg.sv
src/qte_front.sv
src/qte_sqrt_step.sv
src/qte_cordic_step.sv
src/quaternion_to_euler.sv
tb/qte_checker.sv
tb/tb_quaternion_to_euler.sv
